@@ hdl/usb_srr_pkg.sv @@
`timescale 1ns / 1ps

package usb_srr_pkg;

    localparam int DESCRIPTOR_ROM_DEPTH = 128;
    localparam int ROM_AW = $clog2(DESCRIPTOR_ROM_DEPTH);
    localparam int CNT_W  = 6;
    localparam int PC_W   = 4;

    // endpoint-0 action codes
    localparam logic [2:0] ACT_TOGGLE    = 3'd0;
    localparam logic [2:0] ACT_RESET_IN  = 3'd1;
    localparam logic [2:0] ACT_DATA      = 3'd2;
    localparam logic [2:0] ACT_SEND_IN   = 3'd3;
    localparam logic [2:0] ACT_PRIME_OUT = 3'd4;
    localparam logic [2:0] ACT_STALL     = 3'd5;
    localparam logic [2:0] ACT_SET_ADDR  = 3'd6;

    // request codes and descriptor types
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
    localparam logic [7:0] DT_DEVICE          = 8'h01;
    localparam logic [7:0] DT_CONFIG          = 8'h02;
    localparam logic [7:0] DT_STRING          = 8'h03;

    // descriptor layout in the ROM
    localparam logic [ROM_AW-1:0] OFS_DEVICE = ROM_AW'(0);
    localparam logic [ROM_AW-1:0] OFS_CONFIG = ROM_AW'(18);
    localparam logic [ROM_AW-1:0] OFS_STR0   = ROM_AW'(36);
    localparam logic [ROM_AW-1:0] OFS_STR1   = ROM_AW'(40);
    localparam logic [ROM_AW-1:0] OFS_STR2   = ROM_AW'(50);
    localparam logic [CNT_W-1:0]  LEN_DEVICE = CNT_W'(18);
    localparam logic [CNT_W-1:0]  LEN_CONFIG = CNT_W'(18);
    localparam logic [CNT_W-1:0]  LEN_STR0   = CNT_W'(4);
    localparam logic [CNT_W-1:0]  LEN_STR1   = CNT_W'(10);
    localparam logic [CNT_W-1:0]  LEN_STR2   = CNT_W'(34);

    localparam int DESC_TOTAL = 84;
    localparam int DESC_AW    = $clog2(DESC_TOTAL);

    localparam logic [7:0] DESC_BYTES [DESC_TOTAL] = '{
        8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
        8'hd0, 8'h16, 8'h3b, 8'h0f, 8'h01, 8'h01, 8'h01, 8'h02,
        8'h00, 8'h01,
        8'h09, 8'h02, 8'h12, 8'h00, 8'h01, 8'h01, 8'h01, 8'h80,
        8'h32, 8'h09, 8'h04, 8'h00, 8'h00, 8'h00, 8'hfe, 8'h00,
        8'h00, 8'h02,
        8'h04, 8'h03, 8'h09, 8'h04,
        8'h0a, 8'h03, 8'h4c, 8'h00, 8'h55, 8'h00, 8'h4e, 8'h00, 8'h41, 8'h00,
        8'h22, 8'h03,
        8'h54, 8'h00, 8'h72, 8'h00, 8'h69, 8'h00, 8'h2d, 8'h00,
        8'h46, 8'h00, 8'h49, 8'h00, 8'h46, 8'h00, 8'h4f, 8'h00,
        8'h20, 8'h00, 8'h45, 8'h00, 8'h78, 8'h00, 8'h61, 8'h00,
        8'h6d, 8'h00, 8'h70, 8'h00, 8'h6c, 8'h00, 8'h65, 8'h00
    };

    // microprogram entry points
    localparam logic [PC_W-1:0] PC_TOGGLE   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_STALL    = PC_W'(1);
    localparam logic [PC_W-1:0] PC_ADDR     = PC_W'(2);
    localparam logic [PC_W-1:0] PC_ADDR_SET = PC_W'(4);
    localparam logic [PC_W-1:0] PC_CFG      = PC_W'(5);
    localparam logic [PC_W-1:0] PC_DESC     = PC_W'(7);
    localparam logic [PC_W-1:0] PC_DATA     = PC_W'(8);
    localparam logic [PC_W-1:0] PC_DSEND    = PC_W'(9);

    // jump kinds
    localparam logic [2:0] J_NEXT     = 3'd0;
    localparam logic [2:0] J_COND     = 3'd1;
    localparam logic [2:0] J_DISPATCH = 3'd2;
    localparam logic [2:0] J_END      = 3'd3;
    localparam logic [2:0] J_ENDC     = 3'd4;

    // condition selects
    localparam logic [1:0] C_DIR  = 2'd0;
    localparam logic [1:0] C_ZERO = 2'd1;
    localparam logic [1:0] C_MORE = 2'd2;

    typedef struct packed {
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } t_request;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic [6:0] device_address;
        logic       last_action;
    } t_result;

    typedef struct packed {
        logic [2:0]      act;
        logic            emit;
        logic            stat;   // status stage first step: action follows direction
        logic            last;
        logic            lcond;  // last when the condition holds
        logic [2:0]      jkind;
        logic [1:0]      csel;
        logic [PC_W-1:0] target;
        logic            ld;
        logic            adv;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        logic       emit;
        logic [2:0] action;
        logic       last;
        logic       ld;
        logic       adv;
    } t_ctrl;

    // datapath -> sequencer
    typedef struct packed {
        logic            dir;
        logic            zero;
        logic            more;
        logic [PC_W-1:0] dispatch;
    } t_flags;

    function automatic logic [7:0] desc_rom(input logic [ROM_AW-1:0] a);
        logic [7:0] d;
        d = 8'h00;
        if (a < ROM_AW'(DESC_TOTAL))
            d = DESC_BYTES[a[DESC_AW-1:0]];
        return d;
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        w.emit  = 1'b1;
        w.jkind = J_NEXT;
        unique case (pc)
            4'd0: begin
                w.act = ACT_TOGGLE; w.jkind = J_DISPATCH;
            end
            4'd1: begin
                w.act = ACT_STALL; w.last = 1'b1; w.jkind = J_END;
            end
            4'd2: begin
                w.stat = 1'b1; w.jkind = J_COND; w.csel = C_DIR; w.target = PC_ADDR_SET;
            end
            4'd3: begin
                w.act = ACT_SEND_IN;
            end
            4'd4: begin
                w.act = ACT_SET_ADDR; w.last = 1'b1; w.jkind = J_END;
            end
            4'd5: begin
                w.stat = 1'b1; w.lcond = 1'b1; w.jkind = J_ENDC; w.csel = C_DIR;
            end
            4'd6: begin
                w.act = ACT_SEND_IN; w.last = 1'b1; w.jkind = J_END;
            end
            4'd7: begin
                w.act = ACT_RESET_IN; w.ld = 1'b1;
                w.jkind = J_COND; w.csel = C_ZERO; w.target = PC_DSEND;
            end
            4'd8: begin
                w.act = ACT_DATA; w.adv = 1'b1;
                w.jkind = J_COND; w.csel = C_MORE; w.target = PC_DATA;
            end
            4'd9: begin
                w.act = ACT_SEND_IN;
            end
            4'd10: begin
                w.stat = 1'b1; w.lcond = 1'b1; w.jkind = J_ENDC; w.csel = C_DIR;
            end
            4'd11: begin
                w.act = ACT_SEND_IN; w.last = 1'b1; w.jkind = J_END;
            end
            default: begin
                w.act = ACT_STALL; w.last = 1'b1; w.jkind = J_END;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/usb_srr_seq.sv @@
`timescale 1ns / 1ps

module usb_srr_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  usb_srr_pkg::t_flags    i_flags,
    output usb_srr_pkg::t_ctrl     o_ctrl,
    output logic                   o_busy
);

    logic [usb_srr_pkg::PC_W-1:0] r_pc, n_pc;
    logic                         r_busy, n_busy;
    usb_srr_pkg::t_uword          uw;
    logic                         cond;

    assign uw = usb_srr_pkg::ucode(r_pc);

    always_comb begin
        unique case (uw.csel)
            usb_srr_pkg::C_DIR:  cond = i_flags.dir;
            usb_srr_pkg::C_ZERO: cond = i_flags.zero;
            usb_srr_pkg::C_MORE: cond = i_flags.more;
            default:             cond = 1'b0;
        endcase
    end

    always_comb begin
        o_ctrl.emit   = r_busy & uw.emit;
        o_ctrl.action = uw.stat ? (i_flags.dir ? usb_srr_pkg::ACT_PRIME_OUT
                                               : usb_srr_pkg::ACT_RESET_IN)
                                : uw.act;
        o_ctrl.last   = uw.last | (uw.lcond & cond);
        o_ctrl.ld     = r_busy & uw.ld;
        o_ctrl.adv    = r_busy & uw.adv;
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (r_busy) begin
            unique case (uw.jkind)
                usb_srr_pkg::J_NEXT:     n_pc = r_pc + 1'b1;
                usb_srr_pkg::J_COND:     n_pc = cond ? uw.target : r_pc + 1'b1;
                usb_srr_pkg::J_DISPATCH: n_pc = i_flags.dispatch;
                usb_srr_pkg::J_END:      n_busy = 1'b0;
                usb_srr_pkg::J_ENDC: begin
                    if (cond)
                        n_busy = 1'b0;
                    else
                        n_pc = r_pc + 1'b1;
                end
                default:                 n_busy = 1'b0;
            endcase
        end else if (i_accept) begin
            n_pc   = usb_srr_pkg::PC_TOGGLE;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= usb_srr_pkg::PC_TOGGLE;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

@@ hdl/usb_srr_dp.sv @@
`timescale 1ns / 1ps

module usb_srr_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  usb_srr_pkg::t_request  i_request,
    input  usb_srr_pkg::t_ctrl     i_ctrl,
    output usb_srr_pkg::t_flags    o_flags,
    output logic                   o_strobe,
    output usb_srr_pkg::t_result   o_result
);

    usb_srr_pkg::t_request                r_req;
    logic [usb_srr_pkg::ROM_AW-1:0]       r_addr;
    logic [usb_srr_pkg::CNT_W-1:0]        r_cnt;
    logic                                 r_strobe;
    usb_srr_pkg::t_result                 r_result, n_result;

    logic [7:0]                           dtype, dindex;
    logic [usb_srr_pkg::ROM_AW-1:0]       ofs;
    logic [usb_srr_pkg::CNT_W-1:0]        len, n_len;
    logic                                 desc_ok;

    assign dtype  = r_req.request_value[15:8];
    assign dindex = r_req.request_value[7:0];

    always_comb begin
        desc_ok = 1'b1;
        ofs     = usb_srr_pkg::OFS_DEVICE;
        len     = usb_srr_pkg::LEN_DEVICE;
        priority if (dtype == usb_srr_pkg::DT_DEVICE) begin
            ofs = usb_srr_pkg::OFS_DEVICE; len = usb_srr_pkg::LEN_DEVICE;
        end else if (dtype == usb_srr_pkg::DT_CONFIG && dindex == 8'd0) begin
            ofs = usb_srr_pkg::OFS_CONFIG; len = usb_srr_pkg::LEN_CONFIG;
        end else if (dtype == usb_srr_pkg::DT_STRING && dindex == 8'd0) begin
            ofs = usb_srr_pkg::OFS_STR0; len = usb_srr_pkg::LEN_STR0;
        end else if (dtype == usb_srr_pkg::DT_STRING && dindex == 8'd1) begin
            ofs = usb_srr_pkg::OFS_STR1; len = usb_srr_pkg::LEN_STR1;
        end else if (dtype == usb_srr_pkg::DT_STRING && dindex == 8'd2) begin
            ofs = usb_srr_pkg::OFS_STR2; len = usb_srr_pkg::LEN_STR2;
        end else begin
            desc_ok = 1'b0;
        end
    end

    // bytes sent: descriptor length clipped to wLength
    assign n_len = (r_req.request_length < 16'(len))
                   ? r_req.request_length[usb_srr_pkg::CNT_W-1:0] : len;

    always_comb begin
        o_flags.dir  = r_req.request_type[7];
        o_flags.zero = (n_len == '0);
        o_flags.more = (r_cnt > usb_srr_pkg::CNT_W'(1));
        priority if (r_req.request_type[6:5] != 2'b00)
            o_flags.dispatch = usb_srr_pkg::PC_STALL;
        else if (r_req.request_code == usb_srr_pkg::REQ_SET_ADDRESS)
            o_flags.dispatch = usb_srr_pkg::PC_ADDR;
        else if (r_req.request_code == usb_srr_pkg::REQ_SET_CONFIG)
            o_flags.dispatch = (dindex > 8'd1) ? usb_srr_pkg::PC_STALL
                                               : usb_srr_pkg::PC_CFG;
        else if (r_req.request_code == usb_srr_pkg::REQ_GET_DESCRIPTOR)
            o_flags.dispatch = desc_ok ? usb_srr_pkg::PC_DESC : usb_srr_pkg::PC_STALL;
        else
            o_flags.dispatch = usb_srr_pkg::PC_STALL;
    end

    always_comb begin
        n_result                = '0;
        n_result.action         = i_ctrl.action;
        n_result.last_action    = i_ctrl.last;
        if (i_ctrl.action == usb_srr_pkg::ACT_DATA)
            n_result.data_byte = usb_srr_pkg::desc_rom(r_addr);
        if (i_ctrl.action == usb_srr_pkg::ACT_SET_ADDR)
            n_result.device_address = r_req.request_value[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept)
            r_req <= i_request;
        if (i_ctrl.ld) begin
            r_addr <= ofs;
            r_cnt  <= n_len;
        end else if (i_ctrl.adv) begin
            r_addr <= r_addr + 1'b1;
            r_cnt  <= r_cnt - 1'b1;
        end
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctrl.emit;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ hdl/usb_standard_request_responder.sv @@
// The first action follows the sequencer registers (r_pc, r_busy) and then the datapath
// registers (r_result, r_strobe), then one action per cycle; a new setup packet waits until
// idle. The step rate is one microcode word per cycle; a data stage uses one word per byte.
// A new packet is taken the cycle after the last action is registered.
// Synchronous active-low reset returns the sequencer to idle and drops the strobe.
`timescale 1ns / 1ps

module usb_standard_request_responder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  usb_srr_pkg::t_request  i_request,
    output logic                   busy,
    output logic                   o_strobe,
    output usb_srr_pkg::t_result   o_result
);

    logic                 accept;
    usb_srr_pkg::t_ctrl   ctrl;
    usb_srr_pkg::t_flags  flags;

    assign accept = start & ~busy;

    usb_srr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_flags  (flags),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    usb_srr_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_request (i_request),
        .i_ctrl    (ctrl),
        .o_flags   (flags),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

`ifndef NO_ASSERTIONS
    a_strobe_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("action transfer outside a sequence");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_action) |-> !busy)
        else $error("last action while sequencer still running");

    a_end_has_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_result.last_action))
        else $error("sequence ended without a last action");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.action != usb_srr_pkg::ACT_DATA) |->
            (o_result.data_byte == 8'h00))
        else $error("data byte set on a non-data action");

    a_first_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 (o_strobe && o_result.action == usb_srr_pkg::ACT_TOGGLE))
        else $error("sequence does not open with a toggle set");
`endif

endmodule

@@ verif/usb_standard_request_responder_tb.sv @@
`timescale 1ns / 1ps

module usb_standard_request_responder_tb;
    import usb_srr_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_COUNT  = 250;
    localparam int          DIR_IN_BIT    = 7;
    localparam logic [1:0]  TYPE_STANDARD = 2'b00;

    // descriptor layout, kept independent of the design's package
    localparam int DEVICE_AT = 0;
    localparam int DEVICE_LEN = 18;
    localparam int CONFIG_AT = 18;
    localparam int CONFIG_LEN = 18;
    localparam int LANGID_AT = 36;
    localparam int LANGID_LEN = 4;
    localparam int MFR_AT = 40;
    localparam int MFR_LEN = 10;
    localparam int PRODUCT_AT = 50;
    localparam int PRODUCT_LEN = 34;

    logic [7:0] descriptor_bytes [84] = '{
        8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
        8'hd0, 8'h16, 8'h3b, 8'h0f, 8'h01, 8'h01, 8'h01, 8'h02,
        8'h00, 8'h01,
        8'h09, 8'h02, 8'h12, 8'h00, 8'h01, 8'h01, 8'h01, 8'h80,
        8'h32, 8'h09, 8'h04, 8'h00, 8'h00, 8'h00, 8'hfe, 8'h00,
        8'h00, 8'h02,
        8'h04, 8'h03, 8'h09, 8'h04,
        8'h0a, 8'h03, 8'h4c, 8'h00, 8'h55, 8'h00, 8'h4e, 8'h00, 8'h41, 8'h00,
        8'h22, 8'h03,
        8'h54, 8'h00, 8'h72, 8'h00, 8'h69, 8'h00, 8'h2d, 8'h00,
        8'h46, 8'h00, 8'h49, 8'h00, 8'h46, 8'h00, 8'h4f, 8'h00,
        8'h20, 8'h00, 8'h45, 8'h00, 8'h78, 8'h00, 8'h61, 8'h00,
        8'h6d, 8'h00, 8'h70, 8'h00, 8'h6c, 8'h00, 8'h65, 8'h00
    };

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_request i_request;
    logic     busy;
    logic     o_strobe;
    t_result  o_result;

    t_result  expected_actions[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;

    usb_standard_request_responder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_request(i_request),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** usb_standard_request_responder: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic t_result make_action(input logic [2:0] act, input logic [7:0] data,
                                            input logic [6:0] addr);
        t_result r;
        r.action         = act;
        r.data_byte      = data;
        r.device_address = addr;
        r.last_action    = 1'b0;
        return r;
    endfunction

    function automatic void append_status(ref t_result seq[$], input logic dir_in);
        if (dir_in) begin
            seq.push_back(make_action(ACT_PRIME_OUT, 8'h00, 7'h00));
        end else begin
            seq.push_back(make_action(ACT_RESET_IN, 8'h00, 7'h00));
            seq.push_back(make_action(ACT_SEND_IN, 8'h00, 7'h00));
        end
    endfunction

    // Expected endpoint-0 action sequence for one setup transfer.
    task automatic predict_response(input t_request req);
        t_result     seq[$];
        logic [7:0]  desc_type;
        logic [7:0]  desc_index;
        logic        dir_in;
        int unsigned desc_at;
        int unsigned desc_len;
        int unsigned nbytes;
        bit          found;
        desc_type  = req.request_value[15:8];
        desc_index = req.request_value[7:0];
        dir_in     = req.request_type[DIR_IN_BIT];
        desc_at    = 0;
        desc_len   = 0;
        found      = 1'b1;
        seq.push_back(make_action(ACT_TOGGLE, 8'h00, 7'h00));
        if (req.request_type[6:5] != TYPE_STANDARD) begin
            seq.push_back(make_action(ACT_STALL, 8'h00, 7'h00));
        end else if (req.request_code == REQ_SET_ADDRESS) begin
            append_status(seq, dir_in);
            seq.push_back(make_action(ACT_SET_ADDR, 8'h00, req.request_value[6:0]));
        end else if (req.request_code == REQ_SET_CONFIG) begin
            if (desc_index > 8'd1)
                seq.push_back(make_action(ACT_STALL, 8'h00, 7'h00));
            else
                append_status(seq, dir_in);
        end else if (req.request_code == REQ_GET_DESCRIPTOR) begin
            if (desc_type == DT_DEVICE) begin
                desc_at = DEVICE_AT; desc_len = DEVICE_LEN;
            end else if (desc_type == DT_CONFIG && desc_index == 8'd0) begin
                desc_at = CONFIG_AT; desc_len = CONFIG_LEN;
            end else if (desc_type == DT_STRING && desc_index == 8'd0) begin
                desc_at = LANGID_AT; desc_len = LANGID_LEN;
            end else if (desc_type == DT_STRING && desc_index == 8'd1) begin
                desc_at = MFR_AT; desc_len = MFR_LEN;
            end else if (desc_type == DT_STRING && desc_index == 8'd2) begin
                desc_at = PRODUCT_AT; desc_len = PRODUCT_LEN;
            end else begin
                found = 1'b0;
            end
            if (found) begin
                nbytes = (req.request_length < desc_len) ? req.request_length : desc_len;
                seq.push_back(make_action(ACT_RESET_IN, 8'h00, 7'h00));
                for (int i = 0; i < nbytes; i++)
                    seq.push_back(make_action(ACT_DATA, descriptor_bytes[desc_at + i], 7'h00));
                seq.push_back(make_action(ACT_SEND_IN, 8'h00, 7'h00));
                append_status(seq, dir_in);
            end else begin
                seq.push_back(make_action(ACT_STALL, 8'h00, 7'h00));
            end
        end else begin
            seq.push_back(make_action(ACT_STALL, 8'h00, 7'h00));
        end
        seq[seq.size() - 1].last_action = 1'b1;
        foreach (seq[i])
            expected_actions.push_back(seq[i]);
    endtask

    always @(posedge i_clk) begin
        t_result exp_action;
        if (i_rst_n && o_strobe) begin
            if (expected_actions.size() == 0) begin
                report_mismatch($sformatf("unexpected action %0d", o_result.action));
            end else begin
                exp_action = expected_actions.pop_front();
                if (o_result.action !== exp_action.action)
                    report_mismatch($sformatf("action got %0d exp %0d",
                                              o_result.action, exp_action.action));
                if (o_result.data_byte !== exp_action.data_byte)
                    report_mismatch($sformatf("data_byte got %02h exp %02h",
                                              o_result.data_byte, exp_action.data_byte));
                if (o_result.device_address !== exp_action.device_address)
                    report_mismatch($sformatf("device_address got %0d exp %0d",
                                              o_result.device_address,
                                              exp_action.device_address));
                if (o_result.last_action !== exp_action.last_action)
                    report_mismatch($sformatf("last_action got %0b exp %0b",
                                              o_result.last_action, exp_action.last_action));
            end
        end
    end

    // Called at a falling edge; leaves start high with the transfer just taken.
    task automatic send_request(input t_request req);
        i_request = req;
        start     = 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_response(req);
        @(negedge i_clk);
    endtask

    task automatic sender_gap(input bit allowed);
        int unsigned span;
        if (allowed && $urandom_range(0, 99) < 20) begin
            span  = ($urandom_range(0, 9) == 0) ? 40 : 4;
            start = 1'b0;
            repeat ($urandom_range(1, span))
                @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (expected_actions.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_request make_request(input logic [7:0] rtype, input logic [7:0] code,
                                              input logic [15:0] value,
                                              input logic [15:0] length);
        t_request r;
        r.request_type   = rtype;
        r.request_code   = code;
        r.request_value  = value;
        r.request_length = length;
        return r;
    endfunction

    task automatic send_directed(input logic [7:0] rtype, input logic [7:0] code,
                                 input logic [15:0] value, input logic [15:0] length);
        send_request(make_request(rtype, code, value, length));
        sender_gap(1'b1);
    endtask

    task automatic test_set_address();
        send_directed(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000);
        send_directed(8'h80, REQ_SET_ADDRESS, 16'h0000, 16'hFFFF);
        send_directed(8'h1F, REQ_SET_ADDRESS, 16'h5A2B, 16'h1234);
    endtask

    task automatic test_set_configuration();
        send_directed(8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000);
        // high byte of wValue is ignored
        send_directed(8'h80, REQ_SET_CONFIG, 16'hFF00, 16'h0000);
        send_directed(8'h00, REQ_SET_CONFIG, 16'h0002, 16'h0000);
        send_directed(8'h80, REQ_SET_CONFIG, 16'h00FF, 16'hFFFF);
    endtask

    task automatic test_get_descriptor();
        // device index is ignored
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h01FF, 16'hFFFF);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0000);
        send_directed(8'h00, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0001);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h0200, 16'h0009);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h0201, 16'h00FF);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h0300, 16'h00FF);
        send_directed(8'h00, REQ_GET_DESCRIPTOR, 16'h0301, 16'hFFFF);
        // longest sequence: full product string, OUT direction clear
        send_directed(8'h00, REQ_GET_DESCRIPTOR, 16'h0302, 16'hFFFF);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h0303, 16'h0040);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h0400, 16'h0040);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'hFF00, 16'h0040);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h0000, 16'h0040);
    endtask

    task automatic test_rejected_requests();
        send_directed(8'h20, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0040);
        send_directed(8'h40, REQ_SET_ADDRESS, 16'h0011, 16'h0000);
        send_directed(8'hE0, REQ_SET_CONFIG, 16'h0001, 16'h0000);
        send_directed(8'h00, 8'h00, 16'h0000, 16'h0000);
        send_directed(8'h80, 8'hFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        repeat (4)
            @(negedge i_clk);
        send_directed(8'h80, REQ_GET_DESCRIPTOR, 16'h0301, 16'h0005);
    endtask

    function automatic t_request random_request();
        t_request r;
        r.request_type   = 8'($urandom);
        r.request_code   = 8'($urandom);
        r.request_value  = 16'($urandom);
        r.request_length = 16'($urandom);
        // most transfers are well-formed standard requests with random content
        if ($urandom_range(0, 99) < 75) begin
            r.request_type[6:5] = TYPE_STANDARD;
            case ($urandom_range(0, 3))
                0: r.request_code = REQ_SET_ADDRESS;
                1: begin
                    r.request_code = REQ_SET_CONFIG;
                    if ($urandom_range(0, 3) != 0)
                        r.request_value[7:0] = 8'($urandom_range(0, 2));
                end
                default: begin
                    r.request_code = REQ_GET_DESCRIPTOR;
                    if ($urandom_range(0, 4) != 0)
                        r.request_value[15:8] = 8'($urandom_range(1, 3));
                    if ($urandom_range(0, 3) != 0)
                        r.request_value[7:0] = 8'($urandom_range(0, 3));
                    if ($urandom_range(0, 3) != 0)
                        r.request_length = 16'($urandom_range(0, 40));
                end
            endcase
        end
        return r;
    endfunction

    task automatic test_random_requests();
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            send_request(random_request());
            // one long stretch with back-to-back transfers
            sender_gap(!(n >= 100 && n < 160));
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_request = '0;
        repeat (2)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_set_address();
        test_set_configuration();
        test_get_descriptor();
        test_rejected_requests();
        test_drain_pause();
        test_random_requests();

        wait_drained();
        repeat (8)
            @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** usb_standard_request_responder: PASSED **");
        else
            $display("** usb_standard_request_responder: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/usb_srr_pkg.sv
hdl/usb_srr_seq.sv
hdl/usb_srr_dp.sv
hdl/usb_standard_request_responder.sv
verif/usb_standard_request_responder_tb.sv
